>>> sv/tsa_pkg.sv
package tsa_pkg;

    // field widths
    localparam int TS_W    = 64;
    localparam int SEQ_W   = 32;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int FRAME_W = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // stored timestamp width, 32 to 64
    localparam int STAMP_W = 64;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [CFG_W-1:0] MAX_DIFF_RESET = CFG_W'(5000);
    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = CFG_W'(100);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = CFG_IDX_W'(1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_MOTION = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_TOUCH  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(2);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FRAME          = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_MOTION_MISMATCH = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_TOUCH_MISMATCH  = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_MOTION_TIMEOUT  = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_TOUCH_TIMEOUT   = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_BUSY            = KIND_W'(5);

    typedef enum logic [1:0] {
        OP_MOTION,
        OP_TOUCH,
        OP_TICK
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TS_W-1:0]  packet_timestamp_us;
        logic [SEQ_W-1:0] packet_sequence;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [FRAME_W-1:0] frame_number;
        logic [TS_W-1:0]    frame_stamp_us;
        logic [TS_W-1:0]    time_difference_us;
        logic [SEQ_W-1:0]   motion_sequence;
        logic [SEQ_W-1:0]   touch_sequence;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic [STAMP_W-1:0] stamp;
        logic [SEQ_W-1:0]   seq;
    } queue_entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_diff;
        logic [CFG_W-1:0] timeout;
    } cfg_t;

endpackage

>>> sv/tsa_front.sv
module tsa_front
    import tsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  in_item_t     item,
    output logic         q_valid,
    output queue_entry_t q_head,
    input  logic         q_pop
);

    queue_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    push;
    logic                    do_pop;
    queue_entry_t            entry;
    logic                    known_cmd;

    // classify the incoming beat
    always_comb
    begin
        entry.stamp = item.packet_timestamp_us[STAMP_W-1:0];
        entry.seq   = item.packet_sequence;
        entry.op    = OP_TICK;
        known_cmd   = 1'b1;
        case (item.command)
            CMD_MOTION: entry.op = OP_MOTION;
            CMD_TOUCH:  entry.op = OP_TOUCH;
            CMD_TICK:   entry.op = OP_TICK;
            default:    known_cmd = 1'b0;
        endcase
    end

    assign item_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    // unused command is taken and dropped here
    assign push       = item_valid && item_ready && known_cmd;
    assign q_valid    = (count_reg != '0);
    assign q_head     = mem_reg[rd_ptr_reg];
    assign do_pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> sv/tsa_back.sv
module tsa_back
    import tsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  queue_entry_t q_head,
    output logic         q_pop,
    input  cfg_t         cfg,
    output logic         result_valid,
    input  logic         result_ready,
    output out_item_t    result
);

    // slot state
    logic                 m_full_reg, m_full_next;
    logic                 t_full_reg, t_full_next;
    logic [STAMP_W-1:0]   m_ts_reg, m_ts_next;
    logic [STAMP_W-1:0]   t_ts_reg, t_ts_next;
    logic [SEQ_W-1:0]     m_seq_reg, m_seq_next;
    logic [SEQ_W-1:0]     t_seq_reg, t_seq_next;
    logic [CFG_W-1:0]     m_age_reg, m_age_next;
    logic [CFG_W-1:0]     t_age_reg, t_age_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;

    // result register
    logic                 res_valid_reg, res_valid_next;
    out_item_t            res_reg, res_next;

    logic                 fire;
    logic                 has_res;
    logic [STAMP_W-1:0]   m_ts_eff, t_ts_eff;
    logic [SEQ_W-1:0]     m_seq_eff, t_seq_eff;
    logic                 m_ge;
    logic [STAMP_W-1:0]   diff;
    logic                 too_far;
    logic [CFG_W-1:0]     m_age_inc, t_age_inc;

    assign fire  = q_valid && (!res_valid_reg || result_ready);
    assign q_pop = fire;

    // pairing datapath: the arriving packet against the held one
    assign m_ts_eff  = (q_head.op == OP_MOTION) ? q_head.stamp : m_ts_reg;
    assign t_ts_eff  = (q_head.op == OP_TOUCH)  ? q_head.stamp : t_ts_reg;
    assign m_seq_eff = (q_head.op == OP_MOTION) ? q_head.seq   : m_seq_reg;
    assign t_seq_eff = (q_head.op == OP_TOUCH)  ? q_head.seq   : t_seq_reg;
    assign m_ge      = (m_ts_eff >= t_ts_eff);
    assign diff      = m_ge ? (m_ts_eff - t_ts_eff) : (t_ts_eff - m_ts_eff);
    assign too_far   = (diff > STAMP_W'(cfg.max_diff));

    // saturating age
    assign m_age_inc = (m_age_reg == '1) ? m_age_reg : m_age_reg + 1'b1;
    assign t_age_inc = (t_age_reg == '1) ? t_age_reg : t_age_reg + 1'b1;

    always_comb
    begin
        m_full_next = m_full_reg;
        t_full_next = t_full_reg;
        m_ts_next   = m_ts_reg;
        t_ts_next   = t_ts_reg;
        m_seq_next  = m_seq_reg;
        t_seq_next  = t_seq_reg;
        m_age_next  = m_age_reg;
        t_age_next  = t_age_reg;
        frame_next  = frame_reg;
        has_res     = 1'b0;
        res_next    = '0;
        if (fire)
        begin
            case (q_head.op)
                OP_MOTION, OP_TOUCH:
                begin
                    if ((q_head.op == OP_MOTION) ? m_full_reg : t_full_reg)
                    begin
                        has_res              = 1'b1;
                        res_next.result_kind = KIND_BUSY;
                        if (q_head.op == OP_MOTION)
                        begin
                            res_next.motion_sequence = q_head.seq;
                        end
                        else
                        begin
                            res_next.touch_sequence = q_head.seq;
                        end
                    end
                    else
                    begin
                        if (q_head.op == OP_MOTION)
                        begin
                            m_full_next = 1'b1;
                            m_ts_next   = q_head.stamp;
                            m_seq_next  = q_head.seq;
                            m_age_next  = '0;
                        end
                        else
                        begin
                            t_full_next = 1'b1;
                            t_ts_next   = q_head.stamp;
                            t_seq_next  = q_head.seq;
                            t_age_next  = '0;
                        end
                        // other slot full: compare now
                        if ((q_head.op == OP_MOTION) ? t_full_reg : m_full_reg)
                        begin
                            has_res                     = 1'b1;
                            res_next.time_difference_us = TS_W'(diff);
                            res_next.motion_sequence    = m_seq_eff;
                            res_next.touch_sequence     = t_seq_eff;
                            if (too_far)
                            begin
                                // drop the older packet
                                if (!m_ge)
                                begin
                                    res_next.result_kind = KIND_MOTION_MISMATCH;
                                    m_full_next          = 1'b0;
                                end
                                else
                                begin
                                    res_next.result_kind = KIND_TOUCH_MISMATCH;
                                    t_full_next          = 1'b0;
                                end
                            end
                            else
                            begin
                                res_next.result_kind    = KIND_FRAME;
                                res_next.frame_number   = frame_reg;
                                res_next.frame_stamp_us = TS_W'(m_ts_eff);
                                frame_next              = frame_reg + 1'b1;
                                m_full_next             = 1'b0;
                                t_full_next             = 1'b0;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (m_full_reg && !t_full_reg)
                    begin
                        m_age_next = m_age_inc;
                        if (m_age_inc >= cfg.timeout)
                        begin
                            m_full_next              = 1'b0;
                            has_res                  = 1'b1;
                            res_next.result_kind     = KIND_MOTION_TIMEOUT;
                            res_next.motion_sequence = m_seq_reg;
                        end
                    end
                    else if (t_full_reg && !m_full_reg)
                    begin
                        t_age_next = t_age_inc;
                        if (t_age_inc >= cfg.timeout)
                        begin
                            t_full_next             = 1'b0;
                            has_res                 = 1'b1;
                            res_next.result_kind    = KIND_TOUCH_TIMEOUT;
                            res_next.touch_sequence = t_seq_reg;
                        end
                    end
                end
                default:
                begin
                    has_res = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire && has_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_full_reg    <= 1'b0;
            t_full_reg    <= 1'b0;
            m_age_reg     <= '0;
            t_age_reg     <= '0;
            frame_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            m_full_reg    <= m_full_next;
            t_full_reg    <= t_full_next;
            m_age_reg     <= m_age_next;
            t_age_reg     <= t_age_next;
            frame_reg     <= frame_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_ts_reg  <= m_ts_next;
        t_ts_reg  <= t_ts_next;
        m_seq_reg <= m_seq_next;
        t_seq_reg <= t_seq_next;
        if (fire && has_res)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef ASSERT_OFF
    // a pair always resolves in the same step
    a_never_both_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_full_reg && t_full_reg))
        else $error("both slots held after a step");

    // frame id advances on a frame result and only then
    a_frame_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_res && res_next.result_kind == KIND_FRAME)
        |=> (frame_reg == $past(frame_reg) + 1'b1))
        else $error("frame id did not advance on a frame");

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && has_res && res_next.result_kind == KIND_FRAME)
        |=> $stable(frame_reg))
        else $error("frame id moved without a frame");

    // a refused arrival leaves the slots alone
    a_busy_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_res && res_next.result_kind == KIND_BUSY)
        |=> ($stable(m_full_reg) && $stable(t_full_reg)))
        else $error("busy beat changed slot occupancy");
`endif

endmodule

>>> sv/timestamp_pair_aligner_core.sv
// path: an accepted input beat is written into the queue, then the back stage takes it
//   from the queue head and registers any result it gives in the result register
// throughput: one input beat per cycle, set by the back stage that owns
//   both slots; while a result waits the two-entry queue keeps taking beats, then ready drops
// reset (rst_n low, async): both slots empty, ages and frame id zero, registers at
//   max difference 5000 and timeout 100; no clearing pass
module timestamp_pair_aligner_core
    import tsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input beats
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    // result beats
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t         cfg_reg, cfg_next;
    logic         q_valid;
    queue_entry_t q_head;
    logic         q_pop;

    // register writes are taken straight into the registers, so the port never stalls
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_DIFF: cfg_next.max_diff = cfg_data;
                REG_TIMEOUT:  cfg_next.timeout  = cfg_data;
                default:      cfg_next          = cfg_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_diff <= MAX_DIFF_RESET;
            cfg_reg.timeout  <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: takes beats, decodes the command, queues them
    tsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    // back: slot state, pairing, aging, result register
    tsa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> bench/tb_timestamp_pair_aligner_core.sv
`timescale 1ns / 100ps

module tb_timestamp_pair_aligner_core;
    import tsa_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_UNUSED   = CMD_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam int SETTLE_CYCLES = 4;       // queue and result register delay plus margin
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 2000000;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_BEATS   = 150;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
    } reg_wr_t;

    // one line of the directed table: a register write or an input beat,
    // the latter optionally with its result typed in
    typedef struct packed {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        in_item_t             beat;
        bit                   typed;
        out_item_t            want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    in_item_t             item;
    logic                 result_valid;
    logic                 result_ready;
    out_item_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    timestamp_pair_aligner_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // aligner shadow: limits, the two pending slots and the frame counter
    logic [CFG_W-1:0]   lim_diff;
    logic [CFG_W-1:0]   lim_ticks;
    bit                 mot_full;
    bit                 tch_full;
    logic [STAMP_W-1:0] mot_stamp;
    logic [STAMP_W-1:0] tch_stamp;
    logic [SEQ_W-1:0]   mot_seq;
    logic [SEQ_W-1:0]   tch_seq;
    logic [31:0]        mot_age;
    logic [31:0]        tch_age;
    logic [FRAME_W-1:0] next_frame;

    // results still owed by the block, oldest first
    out_item_t due_results[$];
    dir_row_t  dir_rows[$];

    int beats_in;
    int results_seen;
    int n_frames;
    int n_drops;
    int n_timeouts;
    int n_busy;
    int fault_cnt;
    int burst_left;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // both slots are full: pair them or drop the older one
    function automatic void pair_slots(output out_item_t r);
        logic [STAMP_W-1:0] gap;
        r = '0;
        gap = (mot_stamp >= tch_stamp) ? mot_stamp - tch_stamp : tch_stamp - mot_stamp;
        r.time_difference_us = TS_W'(gap);
        r.motion_sequence    = mot_seq;
        r.touch_sequence     = tch_seq;
        if (gap > STAMP_W'(lim_diff)) begin
            // too far apart, the newer packet keeps waiting
            if (mot_stamp < tch_stamp) begin
                r.result_kind = KIND_MOTION_MISMATCH;
                mot_full = 1'b0;
            end
            else begin
                r.result_kind = KIND_TOUCH_MISMATCH;
                tch_full = 1'b0;
            end
        end
        else begin
            r.result_kind    = KIND_FRAME;
            r.frame_number   = next_frame;
            r.frame_stamp_us = TS_W'(mot_stamp);
            next_frame = next_frame + 1'b1;
            mot_full = 1'b0;
            tch_full = 1'b0;
        end
    endfunction

    // next state and result for one accepted input beat
    function automatic void predict_beat(input in_item_t b, output bit got,
                                         output out_item_t r);
        logic [STAMP_W-1:0] stamp;
        stamp = b.packet_timestamp_us[STAMP_W-1:0];
        got = 1'b0;
        r = '0;
        case (b.command)
            CMD_MOTION: begin
                if (mot_full) begin
                    got = 1'b1;
                    r.result_kind     = KIND_BUSY;
                    r.motion_sequence = b.packet_sequence;
                end
                else begin
                    mot_full  = 1'b1;
                    mot_stamp = stamp;
                    mot_seq   = b.packet_sequence;
                    mot_age   = '0;
                    if (tch_full) begin
                        got = 1'b1;
                        pair_slots(r);
                    end
                end
            end
            CMD_TOUCH: begin
                if (tch_full) begin
                    got = 1'b1;
                    r.result_kind    = KIND_BUSY;
                    r.touch_sequence = b.packet_sequence;
                end
                else begin
                    tch_full  = 1'b1;
                    tch_stamp = stamp;
                    tch_seq   = b.packet_sequence;
                    tch_age   = '0;
                    if (mot_full) begin
                        got = 1'b1;
                        pair_slots(r);
                    end
                end
            end
            CMD_TICK: begin
                // ages saturate, only a lone packet ages
                if (mot_full && !tch_full) begin
                    if (mot_age != '1)
                        mot_age = mot_age + 1'b1;
                    if (mot_age >= lim_ticks) begin
                        mot_full = 1'b0;
                        got = 1'b1;
                        r.result_kind     = KIND_MOTION_TIMEOUT;
                        r.motion_sequence = mot_seq;
                    end
                end
                else if (tch_full && !mot_full) begin
                    if (tch_age != '1)
                        tch_age = tch_age + 1'b1;
                    if (tch_age >= lim_ticks) begin
                        tch_full = 1'b0;
                        got = 1'b1;
                        r.result_kind    = KIND_TOUCH_TIMEOUT;
                        r.touch_sequence = tch_seq;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void report_field(input string name, input logic [63:0] want,
                                         input logic [63:0] seen);
        fault_cnt++;
        if (fault_cnt <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    endfunction

    function automatic out_item_t result_of(input logic [KIND_W-1:0] kind,
                                            input logic [FRAME_W-1:0] frame,
                                            input logic [TS_W-1:0] stamp,
                                            input logic [TS_W-1:0] diff,
                                            input logic [SEQ_W-1:0] mseq,
                                            input logic [SEQ_W-1:0] tseq);
        out_item_t r;
        r.result_kind        = kind;
        r.frame_number       = frame;
        r.frame_stamp_us     = stamp;
        r.time_difference_us = diff;
        r.motion_sequence    = mseq;
        r.touch_sequence     = tseq;
        return r;
    endfunction

    function automatic dir_row_t beat_row(input logic [CMD_W-1:0] cmd,
                                          input logic [TS_W-1:0] ts,
                                          input logic [SEQ_W-1:0] seq);
        dir_row_t row;
        row = '0;
        row.beat.command             = cmd;
        row.beat.packet_timestamp_us = ts;
        row.beat.packet_sequence     = seq;
        return row;
    endfunction

    function automatic dir_row_t beat_chk(input logic [CMD_W-1:0] cmd,
                                          input logic [TS_W-1:0] ts,
                                          input logic [SEQ_W-1:0] seq,
                                          input out_item_t want);
        dir_row_t row;
        row = beat_row(cmd, ts, seq);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        dir_row_t row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // timestamp offset around the pairing limit
    function automatic logic [TS_W-1:0] pick_gap();
        logic [TS_W-1:0] lim;
        lim = TS_W'(lim_diff);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return lim;
            2:       return lim + 1;
            3:       return (lim == 0) ? lim : lim - 1;
            4, 5:    return TS_W'($urandom) % (lim + 1);
            6:       return lim + 1 + TS_W'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // sender: bursts of beats with random quiet gaps, predicted at acceptance
    task automatic push_beat(input in_item_t b, input bit typed, input out_item_t want);
        int        gap;
        bit        got;
        out_item_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_beat(b, got, r);
        if (typed)
            due_results.push_back(want);
        else if (got)
            due_results.push_back(r);
        if (b.command != CMD_UNUSED)
            beats_in++;
    endtask

    // hold off the sender until every owed result is back and the pipe is quiet
    task automatic drain_results();
        int waited;
        item_valid <= 1'b0;
        waited = 0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (due_results.size() != 0) begin
            fault_cnt++;
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
            due_results.delete();
        end
        // beats that produce no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // register writes only on an idle block
    task automatic write_regs(input reg_wr_t wr[$]);
        drain_results();
        foreach (wr[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= wr[k].idx;
            cfg_data  <= wr[k].val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (wr[k].idx == REG_MAX_DIFF)
                lim_diff = wr[k].val;
            else if (wr[k].idx == REG_TIMEOUT)
                lim_ticks = wr[k].val;
        end
        cfg_valid <= 1'b0;
    endtask

    // sensor packet, stamped near the partner waiting in the other slot when there is one
    task automatic send_packet(input logic [CMD_W-1:0] cmd);
        in_item_t        b;
        bit              near;
        logic [TS_W-1:0] anchor;
        near   = (cmd == CMD_MOTION) ? tch_full : mot_full;
        anchor = (cmd == CMD_MOTION) ? TS_W'(tch_stamp) : TS_W'(mot_stamp);
        b.command         = cmd;
        b.packet_sequence = $urandom;
        if (near && $urandom_range(0, 9) != 0)
            b.packet_timestamp_us = $urandom_range(0, 1) ? anchor + pick_gap()
                                                         : anchor - pick_gap();
        else begin
            case ($urandom_range(0, 3))
                0:       b.packet_timestamp_us = {$urandom, $urandom};
                1:       b.packet_timestamp_us = TS_W'($urandom);
                2:       b.packet_timestamp_us = {TS_W{1'b1}} - TS_W'($urandom_range(0, 5000));
                default: b.packet_timestamp_us = TS_W'($urandom_range(0, 5000));
            endcase
        end
        push_beat(b, 1'b0, '0);
    endtask

    // tick beats still carry random payload, which the block ignores
    task automatic send_tick();
        in_item_t b;
        b.command             = CMD_TICK;
        b.packet_timestamp_us = {$urandom, $urandom};
        b.packet_sequence     = $urandom;
        push_beat(b, 1'b0, '0);
    endtask

    // one short sequence: mostly well-formed pairings, some aging, busy and noise
    task automatic run_scenario();
        int               pick;
        int               n;
        logic [CMD_W-1:0] s;
        in_item_t         b;
        pick = $urandom_range(0, 99);
        s = $urandom_range(0, 1) ? CMD_TOUCH : CMD_MOTION;
        if (pick < 55) begin
            // lone packet, maybe a tick or two, then its partner
            if (mot_full)
                s = CMD_TOUCH;
            else if (tch_full)
                s = CMD_MOTION;
            else begin
                send_packet(s);
                n = $urandom_range(0, 2);
                repeat (n) send_tick();
                s = (s == CMD_MOTION) ? CMD_TOUCH : CMD_MOTION;
            end
            send_packet(s);
        end
        else if (pick < 75) begin
            // lone packet left to age, ticks straddle the timeout
            if (!mot_full && !tch_full)
                send_packet(s);
            n = (lim_ticks < 8) ? int'(lim_ticks) + 1 : 8;
            n = $urandom_range(1, n);
            repeat (n) send_tick();
        end
        else if (pick < 85) begin
            // second arrival into a held slot
            if (mot_full)
                s = CMD_MOTION;
            else if (tch_full)
                s = CMD_TOUCH;
            else
                send_packet(s);
            send_packet(s);
        end
        else begin
            // anything at all, unused command included
            b.command             = CMD_W'($urandom_range(0, CMD_UNUSED));
            b.packet_timestamp_us = {$urandom, $urandom};
            b.packet_sequence     = $urandom;
            push_beat(b, 1'b0, '0);
        end
    endtask

    // receiver: back-pressure pattern switching among a few stall styles
    initial begin
        int mode;
        int span;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // result checker: every accepted result beat against the oldest owed result
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && result_valid && result_ready) begin
            results_seen++;
            case (result.result_kind)
                KIND_FRAME:                                n_frames++;
                KIND_MOTION_MISMATCH, KIND_TOUCH_MISMATCH: n_drops++;
                KIND_MOTION_TIMEOUT, KIND_TOUCH_TIMEOUT:   n_timeouts++;
                KIND_BUSY:                                 n_busy++;
                default: ;
            endcase
            if (due_results.size() == 0) begin
                fault_cnt++;
                $display("%0t: result beat with nothing expected, expected none, actual %0h",
                         $time, result);
            end
            else begin
                want = due_results.pop_front();
                if (result.result_kind !== want.result_kind)
                    report_field("result_kind", 64'(want.result_kind),
                                 64'(result.result_kind));
                if (result.frame_number !== want.frame_number)
                    report_field("frame_number", 64'(want.frame_number),
                                 64'(result.frame_number));
                if (result.frame_stamp_us !== want.frame_stamp_us)
                    report_field("frame_stamp_us", want.frame_stamp_us,
                                 result.frame_stamp_us);
                if (result.time_difference_us !== want.time_difference_us)
                    report_field("time_difference_us", want.time_difference_us,
                                 result.time_difference_us);
                if (result.motion_sequence !== want.motion_sequence)
                    report_field("motion_sequence", 64'(want.motion_sequence),
                                 64'(result.motion_sequence));
                if (result.touch_sequence !== want.touch_sequence)
                    report_field("touch_sequence", 64'(want.touch_sequence),
                                 64'(result.touch_sequence));
            end
        end
    end

    // stimulus: reset, directed table, then randomized phases under varied limits
    initial begin
        reg_wr_t          wq[$];
        logic [CFG_W-1:0] ph_diff [NUM_PHASES];
        logic [CFG_W-1:0] ph_ticks [NUM_PHASES];
        int               i;
        int               goal;
        bit               held;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;

        // shadow state as the block comes out of reset
        lim_diff   = MAX_DIFF_RESET;
        lim_ticks  = TIMEOUT_RESET;
        mot_full   = 1'b0;
        tch_full   = 1'b0;
        mot_stamp  = '0;
        tch_stamp  = '0;
        mot_seq    = '0;
        tch_seq    = '0;
        mot_age    = '0;
        tch_age    = '0;
        next_frame = '0;
        burst_left = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, first block runs on the reset limits (5000 us, 100 ticks)
        // gap exactly at the limit pairs
        dir_rows.push_back(beat_row(CMD_MOTION, 64'd1000, 32'hFFFF_FFFF));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd6000, 32'd0,
            result_of(KIND_FRAME, 32'd0, 64'd1000, 64'd5000, 32'hFFFF_FFFF, 32'd0)));
        // one past the limit, touch is older and goes
        dir_rows.push_back(beat_row(CMD_TOUCH, 64'd0, 32'd1));
        dir_rows.push_back(beat_chk(CMD_MOTION, 64'd5001, 32'd2,
            result_of(KIND_TOUCH_MISMATCH, 32'd0, 64'd0, 64'd5001, 32'd2, 32'd1)));
        // motion slot still held, so this one is refused
        dir_rows.push_back(beat_chk(CMD_MOTION, 64'd7, 32'd3,
            result_of(KIND_BUSY, 32'd0, 64'd0, 64'd0, 32'd3, 32'd0)));
        dir_rows.push_back(beat_row(CMD_TICK, 64'd0, 32'd0));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd5001, 32'd4,
            result_of(KIND_FRAME, 32'd1, 64'd5001, 64'd0, 32'd2, 32'd4)));
        // tick on empty slots, then the unused command
        dir_rows.push_back(beat_row(CMD_TICK, 64'd0, 32'd0));
        dir_rows.push_back(beat_row(CMD_UNUSED, {TS_W{1'b1}}, 32'hFFFF_FFFF));
        // widest limit, zero timeout
        dir_rows.push_back(reg_row(REG_MAX_DIFF, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(REG_TIMEOUT, 32'd0));
        dir_rows.push_back(beat_row(CMD_MOTION, {TS_W{1'b1}}, 32'd5));
        dir_rows.push_back(beat_chk(CMD_TICK, 64'd0, 32'd0,
            result_of(KIND_MOTION_TIMEOUT, 32'd0, 64'd0, 64'd0, 32'd5, 32'd0)));
        dir_rows.push_back(beat_row(CMD_TOUCH, 64'd0, 32'd6));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd1, 32'd7,
            result_of(KIND_BUSY, 32'd0, 64'd0, 64'd0, 32'd0, 32'd7)));
        dir_rows.push_back(beat_chk(CMD_MOTION, 64'hFFFF_FFFF, 32'd8,
            result_of(KIND_FRAME, 32'd2, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 32'd8, 32'd6)));
        // largest possible gap exceeds even the widest limit
        dir_rows.push_back(beat_row(CMD_MOTION, {TS_W{1'b1}}, 32'd9));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd0, 32'd10,
            result_of(KIND_TOUCH_MISMATCH, 32'd0, 64'd0, {TS_W{1'b1}}, 32'd9, 32'd10)));
        // zero limit, one-tick timeout; writes to unknown indexes must not land
        dir_rows.push_back(reg_row(REG_MAX_DIFF, 32'd0));
        dir_rows.push_back(reg_row(REG_TIMEOUT, 32'd1));
        dir_rows.push_back(reg_row(REG_SPARE_LO, 32'h1234_5678));
        dir_rows.push_back(reg_row(REG_SPARE_HI, 32'hFFFF_FFFF));
        dir_rows.push_back(beat_chk(CMD_TICK, 64'd0, 32'd0,
            result_of(KIND_MOTION_TIMEOUT, 32'd0, 64'd0, 64'd0, 32'd9, 32'd0)));
        dir_rows.push_back(beat_row(CMD_TOUCH, 64'd100, 32'd11));
        dir_rows.push_back(beat_chk(CMD_TICK, 64'd0, 32'd0,
            result_of(KIND_TOUCH_TIMEOUT, 32'd0, 64'd0, 64'd0, 32'd0, 32'd11)));
        dir_rows.push_back(beat_row(CMD_MOTION, 64'd50, 32'd12));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd50, 32'd13,
            result_of(KIND_FRAME, 32'd3, 64'd50, 64'd0, 32'd12, 32'd13)));
        // off by one with a zero limit, motion is older
        dir_rows.push_back(beat_row(CMD_MOTION, 64'd50, 32'd14));
        dir_rows.push_back(beat_chk(CMD_TOUCH, 64'd51, 32'd15,
            result_of(KIND_MOTION_MISMATCH, 32'd0, 64'd0, 64'd1, 32'd14, 32'd15)));
        dir_rows.push_back(beat_chk(CMD_TICK, 64'd0, 32'd0,
            result_of(KIND_TOUCH_TIMEOUT, 32'd0, 64'd0, 64'd0, 32'd0, 32'd15)));

        // walk the table, back-to-back register rows go out as one group
        i = 0;
        while (i < dir_rows.size()) begin
            if (dir_rows[i].is_reg) begin
                wq = {};
                while (i < dir_rows.size() && dir_rows[i].is_reg) begin
                    wq.push_back('{dir_rows[i].reg_idx, dir_rows[i].reg_val});
                    i++;
                end
                write_regs(wq);
            end
            else begin
                push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
                i++;
            end
        end

        // random phases, extremes of both registers among them
        ph_diff  = '{32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd100, 32'hFFFF_FFFF};
        ph_ticks = '{32'd3, 32'd1, 32'd2, 32'd1, 32'd0, 32'd4, 32'hFFFF_FFFE};
        ph_diff[3]  = $urandom;
        ph_ticks[3] = $urandom_range(1, 6);
        for (int p = 0; p < NUM_PHASES; p++) begin
            wq = {};
            wq.push_back('{REG_MAX_DIFF, ph_diff[p]});
            wq.push_back('{REG_TIMEOUT, ph_ticks[p]});
            write_regs(wq);
            goal = beats_in + PHASE_BEATS;
            held = 1'b0;
            while (beats_in < goal) begin
                run_scenario();
                // once per phase the sender waits for the block to catch up
                if (!held && beats_in >= goal - PHASE_BEATS / 2) begin
                    drain_results();
                    held = 1'b1;
                end
            end
        end

        drain_results();

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 beats_in, results_seen, NUM_PHASES + 3);
        $display("frames %0d, mismatch drops %0d, timeouts %0d, busy refusals %0d, faults %0d",
                 n_frames, n_drops, n_timeouts, n_busy, fault_cnt);
        if (fault_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
